[rtl/wfts_pkg.sv]
// ----------------------------------------------------------------------------
// wfts_pkg
// Types, segment breakpoints and fixed-point fit coefficients for the wing
// fuel tank split.
// ----------------------------------------------------------------------------
package wfts_pkg;

    localparam int FUEL_W = 18;
    localparam int TANK_W = 16;
    localparam int COEF_W = 31;
    localparam int PROD_W = COEF_W + FUEL_W;
    localparam int SUM_W  = PROD_W + 2;

    // Upper breakpoint of each fill segment (inclusive).
    localparam logic [FUEL_W-1:0] BRK_A = 18'd18000;
    localparam logic [FUEL_W-1:0] BRK_B = 18'd26000;
    localparam logic [FUEL_W-1:0] BRK_C = 18'd36000;
    localparam logic [FUEL_W-1:0] BRK_D = 18'd47000;
    localparam logic [FUEL_W-1:0] BRK_E = 18'd103788;
    localparam logic [FUEL_W-1:0] BRK_F = 18'd158042;
    localparam logic [FUEL_W-1:0] BRK_G = 18'd215702;
    localparam logic [FUEL_W-1:0] BRK_H = 18'd223088;

    // Offsets subtracted before the half or quarter shares.
    localparam logic [FUEL_W-1:0] OFS_OUTER_LOW = 18'd18000;
    localparam logic [FUEL_W-1:0] OFS_FEED_MID  = 18'd8000;
    localparam logic [FUEL_W-1:0] OFS_INNER_LOW = 18'd36000;
    localparam logic [FUEL_W-1:0] OFS_MID_FILL  = 18'd103788;
    localparam logic [FUEL_W-1:0] OFS_INNER_HI  = 18'd147042;
    localparam logic [FUEL_W-1:0] OFS_OUTER_HI  = 18'd207702;

    // Fixed tank fills.
    localparam logic [TANK_W-1:0] FILL_FEED_LOW  = 16'd4500;
    localparam logic [TANK_W-1:0] FILL_OUTER     = 16'd4000;
    localparam logic [TANK_W-1:0] FILL_FEED_MID  = 16'd7000;
    localparam logic [TANK_W-1:0] FILL_INNER     = 16'd5500;
    localparam logic [TANK_W-1:0] FILL_FEED_IN   = 16'd21836;
    localparam logic [TANK_W-1:0] FILL_FEED_OUT  = 16'd20558;
    localparam logic [TANK_W-1:0] FILL_MID       = 16'd27127;
    localparam logic [TANK_W-1:0] FILL_INNER_TOP = 16'd34330;

    // Linear fit slopes and intercepts, scaled by 2^32.
    localparam logic [COEF_W-1:0] A_DE_FEED_IN   = 31'd1122070417;
    localparam logic [COEF_W-1:0] A_DE_FEED_OUT  = 31'd1025413231;
    localparam logic [COEF_W-1:0] A_TOP_FEED_IN  = 31'd420342146;
    localparam logic [COEF_W-1:0] A_TOP_FEED_OUT = 31'd395883334;
    localparam logic [COEF_W-1:0] A_TOP_MID      = 31'd522370331;
    localparam logic [COEF_W-1:0] A_TOP_INNER    = 31'd661086733;
    localparam logic [COEF_W-1:0] A_TOP_OUTER    = 31'd148150515;

    localparam logic signed [SUM_W-1:0] B_DE_FEED_IN   = -51'sd22672538503770;
    localparam logic signed [SUM_W-1:0] B_DE_FEED_OUT  = -51'sd18129650808230;
    localparam logic signed [SUM_W-1:0] B_TOP_FEED_IN  = 51'sd11617236630;
    localparam logic signed [SUM_W-1:0] B_TOP_FEED_OUT = -51'sd20883632067;
    localparam logic signed [SUM_W-1:0] B_TOP_MID      = -51'sd24974542993;
    localparam logic signed [SUM_W-1:0] B_TOP_INNER    = -51'sd34289856050;
    localparam logic signed [SUM_W-1:0] B_TOP_OUTER    = -51'sd9418738888;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = 51'sd2147483648;

    typedef enum logic [3:0] {
        SEG_A   = 4'd0,
        SEG_B   = 4'd1,
        SEG_C   = 4'd2,
        SEG_D   = 4'd3,
        SEG_E   = 4'd4,
        SEG_F   = 4'd5,
        SEG_G   = 4'd6,
        SEG_H   = 4'd7,
        SEG_TOP = 4'd8
    } seg_t;

    // Registered products between the fit stage and the tank stage.
    typedef struct packed {
        seg_t              seg;
        logic [FUEL_W-1:0] fuel;
        logic [PROD_W-1:0] prod_feed_in;
        logic [PROD_W-1:0] prod_feed_out;
        logic [PROD_W-1:0] prod_mid;
        logic [PROD_W-1:0] prod_inner;
        logic [PROD_W-1:0] prod_outer;
    } fit_pipe_t;

    // One value per tank pair; both wings carry the same quantity.
    typedef struct packed {
        logic [TANK_W-1:0] outer;
        logic [TANK_W-1:0] feed_out;
        logic [TANK_W-1:0] mid;
        logic [TANK_W-1:0] inner;
        logic [TANK_W-1:0] feed_in;
    } tank_pair_t;

    // Add intercept, clamp below zero, round half up, saturate at the field top.
    function automatic logic [TANK_W-1:0] fit_round(
        input logic [PROD_W-1:0]       prod,
        input logic signed [SUM_W-1:0] ofs
    );
        logic signed [SUM_W-1:0] sum;
        logic signed [SUM_W-1:0] rnd;
        logic [SUM_W-34:0]       q;
        logic [TANK_W-1:0]       res;
        sum = $signed({2'b00, prod}) + ofs;
        rnd = sum + ROUND_HALF;
        q   = rnd[SUM_W-2:32];
        if (sum[SUM_W-1]) begin
            res = '0;
        end else if (|q[SUM_W-34:TANK_W]) begin
            res = '1;
        end else begin
            res = q[TANK_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/wfts_fit_stage.sv]
// ----------------------------------------------------------------------------
// wfts_fit_stage
// Decode the fill segment and register the five slope products.
// ----------------------------------------------------------------------------
module wfts_fit_stage
    import wfts_pkg::*;
(
    input  logic              aclk,
    input  logic              en,
    input  logic [FUEL_W-1:0] fuel,
    output fit_pipe_t         pipe
);

    fit_pipe_t         pipe_reg;
    fit_pipe_t         pipe_next;
    seg_t              seg;
    logic [COEF_W-1:0] a_feed_in;
    logic [COEF_W-1:0] a_feed_out;

    always_comb begin
        priority if (fuel <= BRK_A) begin
            seg = SEG_A;
        end else if (fuel <= BRK_B) begin
            seg = SEG_B;
        end else if (fuel <= BRK_C) begin
            seg = SEG_C;
        end else if (fuel <= BRK_D) begin
            seg = SEG_D;
        end else if (fuel <= BRK_E) begin
            seg = SEG_E;
        end else if (fuel <= BRK_F) begin
            seg = SEG_F;
        end else if (fuel <= BRK_G) begin
            seg = SEG_G;
        end else if (fuel <= BRK_H) begin
            seg = SEG_H;
        end else begin
            seg = SEG_TOP;
        end
    end

    // Feed tanks share one multiplier between the two fitted segments.
    assign a_feed_in  = (seg == SEG_TOP) ? A_TOP_FEED_IN  : A_DE_FEED_IN;
    assign a_feed_out = (seg == SEG_TOP) ? A_TOP_FEED_OUT : A_DE_FEED_OUT;

    always_comb begin
        pipe_next.seg           = seg;
        pipe_next.fuel          = fuel;
        pipe_next.prod_feed_in  = PROD_W'(a_feed_in)   * PROD_W'(fuel);
        pipe_next.prod_feed_out = PROD_W'(a_feed_out)  * PROD_W'(fuel);
        pipe_next.prod_mid      = PROD_W'(A_TOP_MID)   * PROD_W'(fuel);
        pipe_next.prod_inner    = PROD_W'(A_TOP_INNER) * PROD_W'(fuel);
        pipe_next.prod_outer    = PROD_W'(A_TOP_OUTER) * PROD_W'(fuel);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pipe_reg <= pipe_next;
        end
    end

    assign pipe = pipe_reg;

endmodule

[rtl/wfts_tank_stage.sv]
// ----------------------------------------------------------------------------
// wfts_tank_stage
// Round the fits, form the fixed and shared fills, and register the result.
// ----------------------------------------------------------------------------
module wfts_tank_stage
    import wfts_pkg::*;
(
    input  logic       aclk,
    input  logic       en,
    input  fit_pipe_t  pipe,
    output tank_pair_t tanks
);

    tank_pair_t              tanks_reg;
    tank_pair_t              tanks_next;
    logic signed [SUM_W-1:0] b_feed_in;
    logic signed [SUM_W-1:0] b_feed_out;
    logic [TANK_W-1:0]       fit_feed_in;
    logic [TANK_W-1:0]       fit_feed_out;
    logic [TANK_W-1:0]       fit_mid;
    logic [TANK_W-1:0]       fit_inner;
    logic [TANK_W-1:0]       fit_outer;
    logic [FUEL_W-1:0]       d_outer_low;
    logic [FUEL_W-1:0]       d_feed_mid;
    logic [FUEL_W-1:0]       d_inner_low;
    logic [FUEL_W-1:0]       d_mid_fill;
    logic [FUEL_W-1:0]       d_inner_hi;
    logic [FUEL_W-1:0]       d_outer_hi;

    assign b_feed_in  = (pipe.seg == SEG_TOP) ? B_TOP_FEED_IN  : B_DE_FEED_IN;
    assign b_feed_out = (pipe.seg == SEG_TOP) ? B_TOP_FEED_OUT : B_DE_FEED_OUT;

    assign fit_feed_in  = fit_round(pipe.prod_feed_in,  b_feed_in);
    assign fit_feed_out = fit_round(pipe.prod_feed_out, b_feed_out);
    assign fit_mid      = fit_round(pipe.prod_mid,      B_TOP_MID);
    assign fit_inner    = fit_round(pipe.prod_inner,    B_TOP_INNER);
    assign fit_outer    = fit_round(pipe.prod_outer,    B_TOP_OUTER);

    // Offsets wrap outside their own segment; only the selected one is used.
    assign d_outer_low = pipe.fuel - OFS_OUTER_LOW;
    assign d_feed_mid  = pipe.fuel - OFS_FEED_MID;
    assign d_inner_low = pipe.fuel - OFS_INNER_LOW;
    assign d_mid_fill  = pipe.fuel - OFS_MID_FILL;
    assign d_inner_hi  = pipe.fuel - OFS_INNER_HI;
    assign d_outer_hi  = pipe.fuel - OFS_OUTER_HI;

    always_comb begin
        tanks_next = '0;
        unique case (pipe.seg)
            SEG_A: begin
                tanks_next.feed_out = TANK_W'(pipe.fuel >> 2);
                tanks_next.feed_in  = TANK_W'(pipe.fuel >> 2);
            end
            SEG_B: begin
                tanks_next.feed_out = FILL_FEED_LOW;
                tanks_next.feed_in  = FILL_FEED_LOW;
                tanks_next.outer    = TANK_W'(d_outer_low >> 1);
            end
            SEG_C: begin
                tanks_next.outer    = FILL_OUTER;
                tanks_next.feed_out = TANK_W'(d_feed_mid >> 2);
                tanks_next.feed_in  = TANK_W'(d_feed_mid >> 2);
            end
            SEG_D: begin
                tanks_next.feed_out = FILL_FEED_MID;
                tanks_next.feed_in  = FILL_FEED_MID;
                tanks_next.outer    = FILL_OUTER;
                tanks_next.inner    = TANK_W'(d_inner_low >> 1);
            end
            SEG_E: begin
                tanks_next.outer    = FILL_OUTER;
                tanks_next.inner    = FILL_INNER;
                tanks_next.feed_in  = fit_feed_in;
                tanks_next.feed_out = fit_feed_out;
            end
            SEG_F: begin
                tanks_next.outer    = FILL_OUTER;
                tanks_next.inner    = FILL_INNER;
                tanks_next.feed_in  = FILL_FEED_IN;
                tanks_next.feed_out = FILL_FEED_OUT;
                tanks_next.mid      = TANK_W'(d_mid_fill >> 1);
            end
            SEG_G: begin
                tanks_next.outer    = FILL_OUTER;
                tanks_next.feed_in  = FILL_FEED_IN;
                tanks_next.feed_out = FILL_FEED_OUT;
                tanks_next.mid      = FILL_MID;
                tanks_next.inner    = TANK_W'(d_inner_hi >> 1);
            end
            SEG_H: begin
                tanks_next.feed_in  = FILL_FEED_IN;
                tanks_next.feed_out = FILL_FEED_OUT;
                tanks_next.mid      = FILL_MID;
                tanks_next.inner    = FILL_INNER_TOP;
                tanks_next.outer    = TANK_W'(d_outer_hi >> 1);
            end
            SEG_TOP: begin
                tanks_next.feed_in  = fit_feed_in;
                tanks_next.feed_out = fit_feed_out;
                tanks_next.mid      = fit_mid;
                tanks_next.inner    = fit_inner;
                tanks_next.outer    = fit_outer;
            end
            default: begin
                tanks_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tanks_reg <= tanks_next;
        end
    end

    assign tanks = tanks_reg;

endmodule

[rtl/wing_fuel_tank_split.sv]
// ----------------------------------------------------------------------------
// wing_fuel_tank_split
// Split a total wing fuel quantity over the ten wing tanks.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_* carries one quantity per transaction (wing_fuel, kg).
//   Master stream m_* returns one transaction per quantity with the ten
//   tank quantities, left outer in the low bits through right outer on top.
//   The three stages are an input register, a register after the slope
//   multipliers, and the result register. Throughput is one transaction per
//   cycle while the receiver does not stall; the multiplier stage holds five
//   parallel multipliers, one per tank pair.
//   The pipeline advances as one whole whenever the result register is empty
//   or the receiver takes its transaction, so s_tready follows m_tready
//   while a result is held. A stalled receiver freezes every stage, and the
//   held result stays on m_tdata.
//   Reset clears the stage valid flags only; data registers keep their
//   contents and nothing is shown until new input arrives.
// ----------------------------------------------------------------------------
module wing_fuel_tank_split
    import wfts_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // [17:0] wing_fuel, [23:18] zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata    // left_outer, left_feed_one, left_mid,
                                    // left_inner, left_feed_two,
                                    // right_feed_three, right_inner,
                                    // right_mid, right_feed_four,
                                    // right_outer; 16 bits each, low first
);

    logic              en;
    logic              in_valid_reg;
    logic              fit_valid_reg;
    logic              out_valid_reg;
    logic [FUEL_W-1:0] fuel_reg;
    fit_pipe_t         pipe;
    tank_pair_t        tanks;

    // Advance all stages together unless a finished result is blocked.
    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            fit_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_tvalid;
            fit_valid_reg <= in_valid_reg;
            out_valid_reg <= fit_valid_reg;
        end
    end

    // Capture the quantity; pad bits are dropped.
    always_ff @(posedge aclk) begin
        if (en) begin
            fuel_reg <= s_tdata[FUEL_W-1:0];
        end
    end

    wfts_fit_stage u_fit (
        .aclk (aclk),
        .en   (en),
        .fuel (fuel_reg),
        .pipe (pipe)
    );

    wfts_tank_stage u_tank (
        .aclk  (aclk),
        .en    (en),
        .pipe  (pipe),
        .tanks (tanks)
    );

    assign m_tvalid = out_valid_reg;

    // Mirror each pair onto both wings.
    assign m_tdata = {tanks.outer,    tanks.feed_out, tanks.mid,
                      tanks.inner,    tanks.feed_in,  tanks.feed_in,
                      tanks.inner,    tanks.mid,      tanks.feed_out,
                      tanks.outer};

`ifndef SYNTHESIS
    // Left and right wings always carry the same quantity per tank pair.
    a_wing_symmetry: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] == m_tdata[159:144]) &&
                     (m_tdata[31:16] == m_tdata[143:128]) &&
                     (m_tdata[47:32] == m_tdata[127:112]) &&
                     (m_tdata[63:48] == m_tdata[111:96]) &&
                     (m_tdata[79:64] == m_tdata[95:80]))
        else $error("wing tank pair mismatch");

    // An accepted quantity reaches the output when the pipeline keeps advancing after it is taken.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) ##1 s_tready ##1 s_tready |=> m_tvalid)
        else $error("accepted quantity did not reach the output");

    // A result only appears when the multiplier stage held a valid item.
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(fit_valid_reg))
        else $error("result appeared without a valid item behind it");

    // A stalled result freezes the stages behind it.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(fuel_reg) && $stable(fit_valid_reg))
        else $error("pipeline moved while the result was blocked");
`endif

endmodule
